/* rtl/core/assert_macros.svh */
// Assertion macros shared by the dither RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define EDD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: assertion failed");
// Check that a condition holds in the cycle after a trigger
`define EDD_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define EDD_ASSERT(lbl, prop)
`define EDD_ASSERT_NEXT(lbl, trig, cons)
`endif
`endif

/* rtl/core/edd_pkg.sv */
// Types, constants and arithmetic helpers for the error diffusion dither.
// No dependencies; used by every module of the block but edd_ram.
package edd_pkg;

    // Geometry limits
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int WREG_W       = 11;
    localparam int HREG_W       = 13;

    // Fixed-point format
    localparam int FRAC_BITS = 12;
    localparam int GRAY_W    = 8;
    localparam int DATA_W    = 16;
    localparam int SUM_W     = DATA_W + 4;
    localparam int PROD_W    = SUM_W + 4;
    localparam logic signed [SUM_W-1:0] ONE  = SUM_W'(1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (DATA_W - 1));

    // Diffusion weights, sixteenths
    localparam logic [2:0] W_RIGHT      = 3'd7;
    localparam logic [2:0] W_DOWN_LEFT  = 3'd3;
    localparam logic [2:0] W_DOWN       = 3'd5;
    localparam logic [2:0] W_DOWN_RIGHT = 3'd1;

    // Register map
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0] w_m1;
        logic [ROW_W-1:0] h_m1;
        logic             restart;
    } t_edd_cfg;

    typedef struct packed {
        logic accept;
        logic advance;
    } t_edd_ctl;

    typedef struct packed {
        logic dot;
        logic row_end;
        logic frame_end;
    } t_edd_res;

    // Clamp a saturating sum to the signed storage range
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Weighted share err * k / 16, rounded toward minus infinity
    function automatic logic signed [SUM_W-1:0] share(input logic signed [SUM_W-1:0] e,
                                                      input logic [2:0] k);
        logic signed [PROD_W-1:0] e_x;
        logic signed [PROD_W-1:0] k_x;
        logic signed [PROD_W-1:0] p;
        e_x = PROD_W'(e);
        k_x = PROD_W'(k);
        p   = e_x * k_x;
        return p[SUM_W+3:4];
    endfunction

    // Last column index of a row from the raw width register
    function automatic logic [COL_W-1:0] eff_w_m1(input logic [WREG_W-1:0] w);
        logic [COL_W-1:0] r;
        if (w == '0) begin
            r = '0;
        end else if (int'(w) > MAX_WIDTH) begin
            r = COL_W'(MAX_WIDTH - 1);
        end else begin
            r = COL_W'(w - WREG_W'(1));
        end
        return r;
    endfunction

    // Last row index of a frame from the raw height register
    function automatic logic [ROW_W-1:0] eff_h_m1(input logic [HREG_W-1:0] h);
        logic [ROW_W-1:0] r;
        if (h == '0) begin
            r = '0;
        end else if (int'(h) > HEIGHT_LIMIT) begin
            r = ROW_W'(HEIGHT_LIMIT - 1);
        end else begin
            r = ROW_W'(h - HREG_W'(1));
        end
        return r;
    endfunction

endpackage

/* rtl/core/edd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module edd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/edd_cfg.sv */
// APB-style register block for frame width and height.
// Depends on edd_pkg.
module edd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [edd_pkg::CFG_AW-1:0]    paddr,
    input  logic [edd_pkg::CFG_DW-1:0]    pwdata,
    output logic [edd_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready,
    output edd_pkg::t_edd_cfg             o_cfg
);

    logic [edd_pkg::WREG_W-1:0] r_width;
    logic [edd_pkg::HREG_W-1:0] r_height;
    logic                       wr_xfer;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_xfer = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= edd_pkg::WREG_W'(640);
            r_height <= edd_pkg::HREG_W'(480);
        end else if (wr_xfer) begin
            case (reg_sel)
                edd_pkg::REG_WIDTH:  r_width  <= pwdata[edd_pkg::WREG_W-1:0];
                edd_pkg::REG_HEIGHT: r_height <= pwdata[edd_pkg::HREG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_sel)
            edd_pkg::REG_WIDTH:  prdata = edd_pkg::CFG_DW'(r_width);
            edd_pkg::REG_HEIGHT: prdata = edd_pkg::CFG_DW'(r_height);
            default:             prdata = '0;
        endcase
    end

    // Effective geometry; any write restarts the frame
    assign o_cfg.w_m1    = edd_pkg::eff_w_m1(r_width);
    assign o_cfg.h_m1    = edd_pkg::eff_h_m1(r_height);
    assign o_cfg.restart = wr_xfer;

endmodule

/* rtl/core/edd_core.sv */
// Dither datapath: pixel position counters, input stage, line buffer and
// error diffusion arithmetic. Depends on edd_pkg, edd_ram, assert_macros.svh.
`include "assert_macros.svh"
module edd_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  edd_pkg::t_edd_cfg            i_cfg,
    input  edd_pkg::t_edd_ctl            i_ctl,
    input  logic [edd_pkg::GRAY_W-1:0]   i_gray_level,
    output edd_pkg::t_edd_res            o_res
);

    localparam int DW = edd_pkg::DATA_W;
    localparam int SW = edd_pkg::SUM_W;
    localparam int CW = edd_pkg::COL_W;
    localparam int RW = edd_pkg::ROW_W;

    // Position of the next pixel to be transferred in
    logic [CW-1:0] r_acol;
    logic [RW-1:0] r_arow;
    logic          acol_last;

    // Input stage
    logic [edd_pkg::GRAY_W-1:0] r_s1_gray;
    logic [CW-1:0]              r_s1_col;
    logic [RW-1:0]              r_s1_row;

    // Same-cycle write bypass for the line buffer read
    logic                 r_byp;
    logic signed [DW-1:0] r_byp_data;

    // Diffusion state
    logic signed [DW-1:0] r_rc;
    logic signed [DW-1:0] r_ph;
    logic signed [DW-1:0] r_pr;
    logic signed [DW-1:0] r_tail;
    logic signed [DW-1:0] n_rc;
    logic signed [DW-1:0] n_ph;
    logic signed [DW-1:0] n_pr;
    logic signed [DW-1:0] n_tail;

    // Line buffer ports
    logic                 ram_we;
    logic [CW-1:0]        ram_waddr;
    logic signed [DW-1:0] ram_wdata;
    logic [DW-1:0]        ram_rdata;

    // Arithmetic
    logic                 last_col;
    logic                 last_row;
    logic                 spread;
    logic signed [DW-1:0] above;
    logic signed [SW-1:0] pix;
    logic signed [SW-1:0] sum;
    logic signed [DW-1:0] corr;
    logic                 dot;
    logic signed [SW-1:0] err;
    logic signed [SW-1:0] e_dl;
    logic signed [SW-1:0] e_d;
    logic signed [SW-1:0] e_dr;
    logic signed [SW-1:0] e_r;
    logic signed [DW-1:0] ph_mid;

    assign acol_last = (r_acol == i_cfg.w_m1);

    // Advance the position counters on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_acol <= '0;
            r_arow <= '0;
        end else if (i_ctl.accept) begin
            if (acol_last) begin
                r_acol <= '0;
                r_arow <= (r_arow == i_cfg.h_m1) ? '0 : r_arow + RW'(1);
            end else begin
                r_acol <= r_acol + CW'(1);
            end
        end
    end

    // Capture the pixel with its position
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_s1_gray <= i_gray_level;
            r_s1_col  <= r_acol;
            r_s1_row  <= r_arow;
        end
    end

    // Note a write landing on the entry being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_ctl.accept) begin
            r_byp <= ram_we && (ram_waddr == r_acol);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_byp_data <= ram_wdata;
        end
    end

    edd_ram #(
        .WIDTH (DW),
        .DEPTH (edd_pkg::MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_ctl.accept),
        .i_raddr (r_acol),
        .o_rdata (ram_rdata)
    );

    // Correct the pixel and quantise it
    always_comb begin
        last_col = (r_s1_col == i_cfg.w_m1);
        last_row = (r_s1_row == i_cfg.h_m1);
        spread   = (r_s1_col != '0) && !last_col && !last_row;

        // Last column of the previous row lives in the tail register
        if (r_s1_row == '0) begin
            above = '0;
        end else if (last_col) begin
            above = r_tail;
        end else if (r_byp) begin
            above = r_byp_data;
        end else begin
            above = signed'(ram_rdata);
        end

        pix  = SW'({r_s1_gray, {(edd_pkg::FRAC_BITS - edd_pkg::GRAY_W){1'b0}}});
        sum  = pix + SW'(r_rc) + SW'(above);
        corr = edd_pkg::sat16(sum);
        dot  = SW'(corr) > edd_pkg::HALF;
        err  = dot ? (SW'(corr) - edd_pkg::ONE) : SW'(corr);

        e_dl = edd_pkg::share(err, edd_pkg::W_DOWN_LEFT);
        e_d  = edd_pkg::share(err, edd_pkg::W_DOWN);
        e_dr = edd_pkg::share(err, edd_pkg::W_DOWN_RIGHT);
        e_r  = edd_pkg::share(err, edd_pkg::W_RIGHT);
    end

    // Spread the error and settle the next-row partial sums
    always_comb begin
        ram_we    = i_ctl.advance && (r_s1_col != '0);
        ram_waddr = r_s1_col - CW'(1);
        ram_wdata = edd_pkg::sat16(SW'(r_ph) + (spread ? e_dl : '0));

        if (spread) begin
            ph_mid = edd_pkg::sat16(SW'(r_pr) + e_d);
            n_pr   = edd_pkg::sat16(e_dr);
            n_rc   = edd_pkg::sat16(e_r);
        end else begin
            ph_mid = r_pr;
            n_pr   = '0;
            n_rc   = '0;
        end

        n_ph   = ph_mid;
        n_tail = r_tail;
        if (last_col) begin
            n_tail = ph_mid;
            n_ph   = '0;
            n_pr   = '0;
            n_rc   = '0;
        end
    end

    // Update the diffusion state as each pixel completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_rc <= '0;
            r_ph <= '0;
            r_pr <= '0;
        end else if (i_ctl.advance) begin
            r_rc <= n_rc;
            r_ph <= n_ph;
            r_pr <= n_pr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_tail <= n_tail;
        end
    end

    assign o_res.dot       = dot;
    assign o_res.row_end   = last_col;
    assign o_res.frame_end = last_col && last_row;

    // Position counters never run past the frame
    `EDD_ASSERT(a_col_range, r_acol <= i_cfg.w_m1)
    `EDD_ASSERT(a_row_range, r_arow <= i_cfg.h_m1)
    // A row wrap on transfer starts the next pixel at column zero
    `EDD_ASSERT_NEXT(a_row_wrap, i_ctl.accept && acol_last && !i_cfg.restart, r_acol == '0)
    // The line buffer is never written while the first column is processed
    `EDD_ASSERT(a_no_wr_col0, !(ram_we && (r_s1_col == '0)))

endmodule

/* rtl/core/error_diffusion_dither_unit.sv */
// Floyd-Steinberg error diffusion dither, top level.
// Holds the transfer control and result register; depends on edd_pkg,
// edd_cfg, edd_core and assert_macros.svh.
//
// Usage:
//   Grayscale pixels arrive in raster order on i_valid / o_ready / i_gray_level.
//   Each pixel gives one result on o_valid / i_ready with o_dot (dithered bit),
//   o_row_end (last pixel of a row) and o_frame_end (last pixel of the frame).
//   Frame width and height are set through the APB-style port (width at 0x0,
//   height at 0x4); a write restarts the frame at column 0, row 0 and must
//   only happen while no pixel is in flight.
//   The pixel moves from the input stage into the result register, where
//   o_valid rises; that move waits while a stalled result is still held.
//   Throughput: one pixel per cycle while i_ready is high, set by the
//   single-pass datapath between the input stage and the result register;
//   the line buffer RAM takes at most one read and one write in each cycle.
//   Reset: counters and carries clear, width 640, height 480; the line buffer
//   needs no clearing pass because the first row of a frame never reads it.
//   Stall: while i_ready is low the result holds, one more pixel is taken into
//   the input stage, and o_ready then drops until the result is taken.
`include "assert_macros.svh"
module error_diffusion_dither_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [edd_pkg::GRAY_W-1:0]    i_gray_level,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_dot,
    output logic                          o_row_end,
    output logic                          o_frame_end,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [edd_pkg::CFG_AW-1:0]    paddr,
    input  logic [edd_pkg::CFG_DW-1:0]    pwdata,
    output logic [edd_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready
);

    edd_pkg::t_edd_cfg cfg;
    edd_pkg::t_edd_ctl ctl;
    edd_pkg::t_edd_res res;

    logic              r_s1_vld;
    logic              r_out_vld;
    edd_pkg::t_edd_res r_out;

    edd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Move the stage forward when the result register is free or draining
    assign ctl.advance = r_s1_vld && (!r_out_vld || i_ready);
    assign o_ready     = !r_s1_vld || ctl.advance;
    assign ctl.accept  = i_valid && o_ready;

    edd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_ctl        (ctl),
        .i_gray_level (i_gray_level),
        .o_res        (res)
    );

    // Input stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (ctl.accept) begin
            r_s1_vld <= 1'b1;
        end else if (ctl.advance) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Result register: load on advance, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ctl.advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.advance) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_dot       = r_out.dot;
    assign o_row_end   = r_out.row_end;
    assign o_frame_end = r_out.frame_end;

    // A stalled result is never dropped
    `EDD_ASSERT_NEXT(a_hold_stall, r_out_vld && !i_ready, r_out_vld)
    // Back-pressure only when both stages are full
    `EDD_ASSERT(a_ready_low, o_ready || (r_s1_vld && r_out_vld))
    // Frame end only ever comes with a row end
    `EDD_ASSERT(a_frame_row, !(r_out_vld && r_out.frame_end && !r_out.row_end))

endmodule
